### sv/gauss_lattice_reduce_2d_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2-D lattice reduction unit
// Immediate-cycle and next-cycle implication checks on clk, gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef GAUSS_LATTICE_REDUCE_2D_UNIT_MACROS_SVH
`define GAUSS_LATTICE_REDUCE_2D_UNIT_MACROS_SVH

// same-cycle implication
`define GLR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GLR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/glr2d_pkg.sv
// ----------------------------------------------------------------------------
// glr2d_pkg
// Shared widths, micro-op codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package glr2d_pkg;

  localparam int VEC_W   = 34;
  localparam int NORM_W  = 64;
  localparam int ACC_W   = 68;
  localparam int LIMIT_W = 8;
  localparam int DET_W   = 33;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd200;
  localparam logic signed [ACC_W-1:0] DOT_SAT = 68'sh0_7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    MUL_AXAX = 4'd0,
    MUL_AYAY = 4'd1,
    MUL_BXBX = 4'd2,
    MUL_BYBY = 4'd3,
    MUL_AXBX = 4'd4,
    MUL_AYBY = 4'd5,
    MUL_AXBY = 4'd6,
    MUL_AYBX = 4'd7,
    MUL_MUAX = 4'd8,
    MUL_MUAY = 4'd9
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     ld_init;
    logic     st_na;
    logic     st_nb;
    logic     st_dot;
    logic     do_was;
    logic     do_swap;
    logic     div_start;
    logic     do_mu;
    logic     upd_bx;
    logic     upd_by;
    logic     do_chk;
    logic     publish;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic limit_zero;
    logic div_done;
    logic stop;
  } sts_t;

endpackage

### sv/glr2d_div.sv
// ----------------------------------------------------------------------------
// glr2d_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module glr2d_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic [63:0] quotient,
  output logic [63:0] remainder,
  output logic        done
);
  import glr2d_pkg::*;

  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [64:0] rem_sh;
  logic [64:0] rem_dif;

  always_comb begin
    rem_sh  = {rem_r, quo_r[63]};
    rem_dif = rem_sh - {1'b0, dvs_r};
    if (!rem_dif[64]) begin
      rem_nxt = rem_dif[63:0];
      quo_nxt = {quo_r[62:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[63:0];
      quo_nxt = {quo_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

### sv/glr2d_dpath.sv
// ----------------------------------------------------------------------------
// glr2d_dpath
// Basis registers, shared 34x34 multiplier with accumulator, divider and
// result registers.
// ----------------------------------------------------------------------------
`include "gauss_lattice_reduce_2d_unit_macros.svh"

module glr2d_dpath #(
  parameter int FACTOR_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  glr2d_pkg::cmd_t             cmd,
  output glr2d_pkg::sts_t             sts,
  input  logic [31:0]                 in_factor_first,
  input  logic [31:0]                 in_factor_second,
  input  logic                        cfg_we,
  input  logic [7:0]                  cfg_data,
  output logic                        out_valid,
  output logic signed [33:0]          out_short_x,
  output logic signed [33:0]          out_short_y,
  output logic signed [33:0]          out_long_x,
  output logic signed [33:0]          out_long_y,
  output logic [63:0]                 out_shortest_norm_sq,
  output logic [63:0]                 out_longer_norm_sq,
  output logic signed [63:0]          out_reduced_dot,
  output logic [32:0]                 out_lattice_det,
  output logic                        out_was_reduced,
  output logic                        out_zero_input,
  output logic [7:0]                  out_rounds_used,
  output logic                        out_hit_limit
);
  import glr2d_pkg::*;

  localparam logic [31:0] FMASK = 32'((64'd1 << FACTOR_BITS) - 64'd1);

  logic signed [VEC_W-1:0]  ax_r, ay_r, bx_r, by_r, mu_r;
  logic [NORM_W-1:0]        na_r, nb_r, nb_old_r;
  logic signed [ACC_W-1:0]  dot_r, acc_r, prod_r;
  logic signed [VEC_W-1:0]  op_a, op_b;
  logic [LIMIT_W-1:0]       limit_r, count_r;
  logic                     zero_r, hit_r, was_r, out_valid_r;
  logic [31:0]              p_m, q_m, lo_v, hi_v;
  logic signed [ACC_W-1:0]  dot_mag, acc_mag;
  logic [64:0]              dm2;
  logic [63:0]              quo, rem, mm;
  logic                     div_done;
  logic                     conv;
  logic signed [63:0]       dot_sat;

  logic signed [33:0] o_sx_r, o_sy_r, o_lx_r, o_ly_r;
  logic [63:0]        o_sn_r, o_ln_r;
  logic signed [63:0] o_dot_r;
  logic [32:0]        o_det_r;
  logic               o_was_r, o_zero_r, o_hit_r;
  logic [7:0]         o_rnd_r;

  assign p_m  = in_factor_first & FMASK;
  assign q_m  = in_factor_second & FMASK;
  assign lo_v = (p_m > q_m) ? q_m : p_m;
  assign hi_v = (p_m > q_m) ? p_m : q_m;

  always_comb begin
    case (cmd.mul_sel)
      MUL_AXAX: begin op_a = ax_r; op_b = ax_r; end
      MUL_AYAY: begin op_a = ay_r; op_b = ay_r; end
      MUL_BXBX: begin op_a = bx_r; op_b = bx_r; end
      MUL_BYBY: begin op_a = by_r; op_b = by_r; end
      MUL_AXBX: begin op_a = ax_r; op_b = bx_r; end
      MUL_AYBY: begin op_a = ay_r; op_b = by_r; end
      MUL_AXBY: begin op_a = ax_r; op_b = by_r; end
      MUL_AYBX: begin op_a = ay_r; op_b = bx_r; end
      MUL_MUAX: begin op_a = mu_r; op_b = ax_r; end
      MUL_MUAY: begin op_a = mu_r; op_b = ay_r; end
      default:  begin op_a = ax_r; op_b = ax_r; end
    endcase
  end

  assign dot_mag = dot_r[ACC_W-1] ? -dot_r : dot_r;
  assign acc_mag = acc_r[ACC_W-1] ? -acc_r : acc_r;
  assign dm2     = {dot_mag[63:0], 1'b0};
  assign conv    = (nb_r >= nb_old_r);

  always_comb begin
    if (na_r == '0) begin
      mm = '0;
    end else begin
      mm = quo + {63'd0, (rem >= (na_r - rem))};
    end
  end

  always_comb begin
    if (dot_r > DOT_SAT) begin
      dot_sat = DOT_SAT[63:0];
    end else if (dot_r < -DOT_SAT) begin
      dot_sat = 64'(-DOT_SAT);
    end else begin
      dot_sat = dot_r[63:0];
    end
  end

  glr2d_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (dot_mag[63:0]),
    .divisor   (na_r),
    .quotient  (quo),
    .remainder (rem),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r    <= '0;
      ay_r    <= '0;
      bx_r    <= '0;
      by_r    <= '0;
      count_r <= '0;
      zero_r  <= 1'b0;
      hit_r   <= 1'b1;
      was_r   <= 1'b0;
    end else begin
      if (cmd.ld_init) begin
        count_r <= '0;
        hit_r   <= 1'b1;
        was_r   <= 1'b0;
        zero_r  <= (p_m == '0) || (q_m == '0);
        if ((p_m == '0) || (q_m == '0)) begin
          ax_r <= '0;
          ay_r <= '0;
          bx_r <= '0;
          by_r <= '0;
        end else begin
          ax_r <= 34'sd1;
          ay_r <= $signed({2'b00, hi_v});
          bx_r <= 34'sd1;
          by_r <= $signed(34'd0 - {2'b00, lo_v});
        end
      end
      if (cmd.do_swap && (na_r > nb_r)) begin
        ax_r <= bx_r;
        ay_r <= by_r;
        bx_r <= ax_r;
        by_r <= ay_r;
      end
      if (cmd.upd_bx) begin
        bx_r <= bx_r - prod_r[VEC_W-1:0];
      end
      if (cmd.upd_by) begin
        by_r <= by_r - prod_r[VEC_W-1:0];
      end
      if (cmd.do_was) begin
        was_r <= (dm2 <= {1'b0, na_r});
      end
      if (cmd.do_chk) begin
        count_r <= count_r + 8'd1;
        if (conv) begin
          hit_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    case (cmd.acc_op)
      ACC_LOAD: acc_r <= prod_r;
      ACC_ADD:  acc_r <= acc_r + prod_r;
      ACC_SUB:  acc_r <= acc_r - prod_r;
      default:  acc_r <= acc_r;
    endcase
    if (cmd.st_na) begin
      na_r <= acc_r[NORM_W-1:0];
    end
    if (cmd.st_nb) begin
      nb_r <= acc_r[NORM_W-1:0];
    end
    if (cmd.st_dot) begin
      dot_r <= acc_r;
    end
    if (cmd.do_swap) begin
      if (na_r > nb_r) begin
        na_r     <= nb_r;
        nb_r     <= na_r;
        nb_old_r <= na_r;
      end else begin
        nb_old_r <= nb_r;
      end
    end
    if (cmd.do_mu) begin
      mu_r <= dot_r[ACC_W-1] ? $signed(34'd0 - mm[VEC_W-1:0]) : $signed(mm[VEC_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.publish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      if (zero_r) begin
        o_sx_r   <= '0;
        o_sy_r   <= '0;
        o_lx_r   <= '0;
        o_ly_r   <= '0;
        o_sn_r   <= '0;
        o_ln_r   <= '0;
        o_dot_r  <= '0;
        o_det_r  <= '0;
        o_was_r  <= 1'b0;
        o_rnd_r  <= '0;
        o_hit_r  <= 1'b0;
      end else begin
        if (na_r <= nb_r) begin
          o_sx_r <= ax_r;
          o_sy_r <= ay_r;
          o_lx_r <= bx_r;
          o_ly_r <= by_r;
          o_sn_r <= na_r;
          o_ln_r <= nb_r;
        end else begin
          o_sx_r <= bx_r;
          o_sy_r <= by_r;
          o_lx_r <= ax_r;
          o_ly_r <= ay_r;
          o_sn_r <= nb_r;
          o_ln_r <= na_r;
        end
        o_dot_r <= dot_sat;
        o_det_r <= acc_mag[DET_W-1:0];
        o_was_r <= was_r;
        o_rnd_r <= count_r;
        o_hit_r <= hit_r;
      end
      o_zero_r <= zero_r;
    end
  end

  assign sts.zero       = zero_r;
  assign sts.limit_zero = (limit_r == '0);
  assign sts.div_done   = div_done;
  assign sts.stop       = conv || (({1'b0, count_r} + 9'd1) == {1'b0, limit_r});

  assign out_valid            = out_valid_r;
  assign out_short_x          = o_sx_r;
  assign out_short_y          = o_sy_r;
  assign out_long_x           = o_lx_r;
  assign out_long_y           = o_ly_r;
  assign out_shortest_norm_sq = o_sn_r;
  assign out_longer_norm_sq   = o_ln_r;
  assign out_reduced_dot      = o_dot_r;
  assign out_lattice_det      = o_det_r;
  assign out_was_reduced      = o_was_r;
  assign out_zero_input       = o_zero_r;
  assign out_rounds_used      = o_rnd_r;
  assign out_hit_limit        = o_hit_r;

  `GLR_ASSERT_NXT(a_pub_strobe, cmd.publish, out_valid_r, "publish did not raise out_valid")
  `GLR_ASSERT_IMP(a_zero_rounds, out_valid_r && o_zero_r, o_rnd_r == '0 && !o_hit_r,
                  "zero input result carries rounds")
  `GLR_ASSERT_NXT(a_div_clear, cmd.div_start, !div_done, "divider done not cleared on start")

endmodule

### sv/glr2d_ctrl.sv
// ----------------------------------------------------------------------------
// glr2d_ctrl
// Micro-op sequencer: norms and dot, swap, divide, update, check, finish.
// ----------------------------------------------------------------------------
`include "gauss_lattice_reduce_2d_unit_macros.svh"

module glr2d_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  glr2d_pkg::sts_t sts,
  output glr2d_pkg::cmd_t cmd
);
  import glr2d_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_INIT  = 23'h000002,
    S_C0    = 23'h000004,
    S_C1    = 23'h000008,
    S_C2    = 23'h000010,
    S_C3    = 23'h000020,
    S_C4    = 23'h000040,
    S_C5    = 23'h000080,
    S_C6    = 23'h000100,
    S_C7    = 23'h000200,
    S_WAS   = 23'h000400,
    S_SWAP  = 23'h000800,
    S_DIVLD = 23'h001000,
    S_DIVW  = 23'h002000,
    S_MU    = 23'h004000,
    S_U0    = 23'h008000,
    S_U1    = 23'h010000,
    S_U2    = 23'h020000,
    S_CHK   = 23'h040000,
    S_D0    = 23'h080000,
    S_D1    = 23'h100000,
    S_D2    = 23'h200000,
    S_PUB   = 23'h400000
  } state_t;

  state_t state_r, state_nxt;
  logic   ret_r, ret_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld_init = 1'b1;
          ret_nxt     = 1'b0;
          state_nxt   = S_INIT;
        end
      end
      S_INIT:  state_nxt = sts.zero ? S_PUB : S_C0;
      S_C0: begin
        cmd.mul_sel = MUL_AXAX;
        state_nxt   = S_C1;
      end
      S_C1: begin
        cmd.mul_sel = MUL_AYAY;
        cmd.acc_op  = ACC_LOAD;
        state_nxt   = S_C2;
      end
      S_C2: begin
        cmd.mul_sel = MUL_BXBX;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = S_C3;
      end
      S_C3: begin
        cmd.mul_sel = MUL_BYBY;
        cmd.acc_op  = ACC_LOAD;
        cmd.st_na   = 1'b1;
        state_nxt   = S_C4;
      end
      S_C4: begin
        cmd.mul_sel = MUL_AXBX;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = S_C5;
      end
      S_C5: begin
        cmd.mul_sel = MUL_AYBY;
        cmd.acc_op  = ACC_LOAD;
        cmd.st_nb   = 1'b1;
        state_nxt   = S_C6;
      end
      S_C6: begin
        cmd.acc_op = ACC_ADD;
        state_nxt  = S_C7;
      end
      S_C7: begin
        cmd.st_dot = 1'b1;
        state_nxt  = ret_r ? S_CHK : S_WAS;
      end
      S_WAS: begin
        cmd.do_was = 1'b1;
        ret_nxt    = 1'b1;
        state_nxt  = sts.limit_zero ? S_D0 : S_SWAP;
      end
      S_SWAP: begin
        cmd.do_swap = 1'b1;
        state_nxt   = S_DIVLD;
      end
      S_DIVLD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          state_nxt = S_MU;
        end
      end
      S_MU: begin
        cmd.do_mu = 1'b1;
        state_nxt = S_U0;
      end
      S_U0: begin
        cmd.mul_sel = MUL_MUAX;
        state_nxt   = S_U1;
      end
      S_U1: begin
        cmd.mul_sel = MUL_MUAY;
        cmd.upd_bx  = 1'b1;
        state_nxt   = S_U2;
      end
      S_U2: begin
        cmd.upd_by = 1'b1;
        state_nxt  = S_C0;
      end
      S_CHK: begin
        cmd.do_chk = 1'b1;
        state_nxt  = sts.stop ? S_D0 : S_SWAP;
      end
      S_D0: begin
        cmd.mul_sel = MUL_AXBY;
        state_nxt   = S_D1;
      end
      S_D1: begin
        cmd.mul_sel = MUL_AYBX;
        cmd.acc_op  = ACC_LOAD;
        state_nxt   = S_D2;
      end
      S_D2: begin
        cmd.acc_op = ACC_SUB;
        state_nxt  = S_PUB;
      end
      S_PUB: begin
        cmd.publish = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `GLR_ASSERT_NXT(a_start_init, start && !busy, state_r == S_INIT, "start not taken")
  `GLR_ASSERT_NXT(a_div_exit, state_r == S_DIVW && sts.div_done, state_r == S_MU,
                  "divider result not consumed")
  `GLR_ASSERT_IMP(a_chk_ret, state_r == S_CHK, ret_r, "round check outside rounds")

endmodule

### sv/gauss_lattice_reduce_2d_unit.sv
// ----------------------------------------------------------------------------
// gauss_lattice_reduce_2d_unit
// Lagrange-Gauss reduction of the basis (1,hi),(1,-lo), hi/lo the larger/smaller of a factor pair.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Beat
// in_       input      start & !busy         factor_first, factor_second
// out_      output     out_valid, 1 cycle    reduced basis, norms, dot, flags
// cfg_      input      cfg_valid & cfg_ready round_limit (8 bits)
//
// A zero input goes straight to the result; otherwise R rounds run,
// R = 0..round_limit. The next start is taken at the edge that ends the
// result strobe. Each round uses the one-bit-per-cycle divider plus the
// shared 34x34 multiplier stepping through norms, dot and the basis update.
// Reset: synchronous active-low rst_n; round_limit returns to 200.
// The result strobe lasts one cycle and cannot be stalled; busy holds off start.
// ----------------------------------------------------------------------------
module gauss_lattice_reduce_2d_unit #(
  parameter int FACTOR_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_factor_first,
  input  logic [31:0]        in_factor_second,
  output logic               out_valid,
  output logic signed [33:0] out_short_x,
  output logic signed [33:0] out_short_y,
  output logic signed [33:0] out_long_x,
  output logic signed [33:0] out_long_y,
  output logic [63:0]        out_shortest_norm_sq,
  output logic [63:0]        out_longer_norm_sq,
  output logic signed [63:0] out_reduced_dot,
  output logic [32:0]        out_lattice_det,
  output logic               out_was_reduced,
  output logic               out_zero_input,
  output logic [7:0]         out_rounds_used,
  output logic               out_hit_limit,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import glr2d_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  glr2d_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  glr2d_dpath #(
    .FACTOR_BITS (FACTOR_BITS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_factor_first      (in_factor_first),
    .in_factor_second     (in_factor_second),
    .cfg_we               (cfg_valid & cfg_ready),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_short_x          (out_short_x),
    .out_short_y          (out_short_y),
    .out_long_x           (out_long_x),
    .out_long_y           (out_long_y),
    .out_shortest_norm_sq (out_shortest_norm_sq),
    .out_longer_norm_sq   (out_longer_norm_sq),
    .out_reduced_dot      (out_reduced_dot),
    .out_lattice_det      (out_lattice_det),
    .out_was_reduced      (out_was_reduced),
    .out_zero_input       (out_zero_input),
    .out_rounds_used      (out_rounds_used),
    .out_hit_limit        (out_hit_limit)
  );

endmodule
